@@ sv/ole_pkg.sv @@
package ole_pkg;

    // Default number of list entries.
    localparam int CAPACITY_DEF = 64;

    // Fixed field widths of the request and result beats.
    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      entry_count;
    } t_res;

endpackage

@@ sv/ole_ram.sv @@
module ole_ram #(
    parameter int DEPTH = ole_pkg::CAPACITY_DEF,
    parameter int WIDTH = ole_pkg::VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ole_seq.sv @@
module ole_seq #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ole_pkg::MODE_W-1:0]        i_mode,
    input  logic [ole_pkg::POS_W-1:0]         i_position,
    input  logic signed [ole_pkg::VAL_W-1:0]  i_value,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output ole_pkg::t_res                     o_res,
    output logic                              o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]       o_ram_waddr,
    output logic [ole_pkg::VAL_W-1:0]         o_ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]       o_ram_raddr,
    input  logic [ole_pkg::VAL_W-1:0]         i_ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

    ole_pkg::t_state r_state, n_state;

    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_pend, n_pend;
    logic [AW-1:0]                  r_pend_addr, n_pend_addr;
    logic [AW-1:0]                  r_posm1, n_posm1;
    logic [ole_pkg::VAL_W-1:0]      r_val, n_val;
    logic [ole_pkg::VAL_W-1:0]      r_rd, n_rd;
    logic                           r_found, n_found;
    logic [ole_pkg::STATUS_W-1:0]   r_status, n_status;

    logic          accept;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] cnt_out_x;
    logic          full;
    logic          rw_ok;
    logic          ins_ok;
    logic [AW-1:0] in_addr;
    logic          hit;
    logic          shift_more;
    logic          shift_last;
    logic          scan_end;

    assign accept     = i_in_valid && (r_state == ole_pkg::S_IDLE);
    assign pos_x      = XW'(i_position);
    assign cnt_x      = XW'(r_count);
    assign full       = (cnt_x == XW'(CAPACITY));
    assign rw_ok      = (pos_x != '0) && (pos_x <= cnt_x);
    assign ins_ok     = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
    assign in_addr    = AW'(pos_x - XW'(1));
    assign hit        = (i_ram_rdata == r_val);
    assign shift_more = (r_idx > CW'(r_posm1));
    assign shift_last = !r_pend && (r_idx == CW'(r_posm1));
    assign scan_end   = hit || (r_idx == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ole_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        ole_pkg::MODE_READ: begin
                            n_state = rw_ok ? ole_pkg::S_RDWAIT : ole_pkg::S_DONE;
                        end
                        ole_pkg::MODE_INSERT: begin
                            n_state = (!full && ins_ok) ? ole_pkg::S_SHIFT : ole_pkg::S_DONE;
                        end
                        ole_pkg::MODE_SEARCH: begin
                            n_state = (r_count != '0) ? ole_pkg::S_SCAN : ole_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ole_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ole_pkg::S_RDWAIT: begin
                n_state = ole_pkg::S_DONE;
            end
            ole_pkg::S_SHIFT: begin
                if (shift_last) begin
                    n_state = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = ole_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb begin
        o_in_stall  = (r_state != ole_pkg::S_IDLE);
        o_res_valid = (r_state == ole_pkg::S_DONE);
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = i_value;
        o_ram_raddr = '0;
        case (r_state)
            ole_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        ole_pkg::MODE_READ: begin
                            o_ram_raddr = in_addr;
                        end
                        ole_pkg::MODE_OVERWRITE: begin
                            o_ram_we    = rw_ok;
                            o_ram_waddr = in_addr;
                        end
                        ole_pkg::MODE_APPEND: begin
                            o_ram_we    = !full;
                            o_ram_waddr = r_count[AW-1:0];
                        end
                        default: begin
                            o_ram_raddr = '0;
                        end
                    endcase
                end
            end
            ole_pkg::S_SHIFT: begin
                // The entry read last cycle moves up one place; once the gap
                // reaches the target position the new value fills it.
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_pend_addr;
                    o_ram_wdata = i_ram_rdata;
                end else if (shift_last) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_posm1;
                    o_ram_wdata = r_val;
                end
                if (shift_more) begin
                    o_ram_raddr = AW'(r_idx - CW'(1));
                end
            end
            ole_pkg::S_SCAN: begin
                o_ram_raddr = r_idx[AW-1:0];
            end
            default: begin
                o_ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_posm1     = r_posm1;
        n_val       = r_val;
        n_rd        = r_rd;
        n_found     = r_found;
        n_status    = r_status;
        case (r_state)
            ole_pkg::S_IDLE: begin
                if (accept) begin
                    n_val    = i_value;
                    n_posm1  = in_addr;
                    n_rd     = '0;
                    n_found  = 1'b0;
                    n_status = ole_pkg::ST_OK;
                    n_pend   = 1'b0;
                    case (i_mode)
                        ole_pkg::MODE_READ, ole_pkg::MODE_OVERWRITE: begin
                            if (!rw_ok) begin
                                n_status = ole_pkg::ST_BADPOS;
                            end
                        end
                        ole_pkg::MODE_APPEND: begin
                            if (full) begin
                                n_status = ole_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        ole_pkg::MODE_INSERT: begin
                            if (full) begin
                                n_status = ole_pkg::ST_FULL;
                            end else if (!ins_ok) begin
                                n_status = ole_pkg::ST_BADPOS;
                            end
                            n_idx = r_count;
                        end
                        ole_pkg::MODE_SEARCH: begin
                            n_idx = CW'(1);
                        end
                        ole_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ole_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ole_pkg::S_RDWAIT: begin
                n_rd = i_ram_rdata;
            end
            ole_pkg::S_SHIFT: begin
                if (shift_more) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                    n_idx       = r_idx - CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (shift_last) begin
                    n_count = r_count + CW'(1);
                end
            end
            ole_pkg::S_SCAN: begin
                n_found = hit;
                if (!scan_end) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_posm1     <= n_posm1;
        r_val       <= n_val;
        r_rd        <= n_rd;
        r_found     <= n_found;
        r_status    <= n_status;
    end

    assign cnt_out_x = XW'(r_count);

    always_comb begin
        o_res.read_value  = r_rd;
        o_res.found       = r_found;
        o_res.status      = r_status;
        o_res.entry_count = cnt_out_x[ole_pkg::COUNT_W-1:0];
    end

endmodule

@@ sv/ordered_list_engine.sv @@
// Channel   Direction  Valid         Stall         Payload
// request   in         i_in_valid    o_in_stall    i_mode, i_position, i_value
// result    out        o_out_valid   i_out_stall   o_read_value, o_found, o_status,
//                                                  o_entry_count
//
// Each request beat gives exactly one result beat. Requests are taken one at a
// time; a read passes through a read wait before its result, while overwrite,
// append, clear and refused requests go straight to the result. Inserts and
// searches walk the entries one by one, set by the single read and single
// write port of the entry memory, so their cost grows with the list length.
// Reset is synchronous and active low; it empties the list at once, without a
// pass over the memory. A stalled result waits in the output register while
// the next request is taken and worked on.
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ole_pkg::MODE_W-1:0]        i_mode,
    input  logic [ole_pkg::POS_W-1:0]         i_position,
    input  logic signed [ole_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ole_pkg::VAL_W-1:0]  o_read_value,
    output logic                              o_found,
    output logic [ole_pkg::STATUS_W-1:0]      o_status,
    output logic [ole_pkg::COUNT_W-1:0]       o_entry_count
);

    localparam int AW = $clog2(CAPACITY);

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ole_pkg::VAL_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [ole_pkg::VAL_W-1:0] ram_rdata;

    logic          res_valid;
    logic          out_free;
    ole_pkg::t_res res;

    logic          r_out_valid;
    ole_pkg::t_res r_out;

    // The entry memory holds the list in order, entry k of the list at
    // address k - 1. Its contents need no reset: only entries below the count
    // are ever used, and those have always been written.
    ole_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ole_pkg::VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The sequencer holds the count and walks the memory for inserts and
    // searches, at most one read and one write per cycle.
    ole_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // The output register is free when it is empty or its beat leaves now.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out.read_value;
    assign o_found       = r_out.found;
    assign o_status      = r_out.status;
    assign o_entry_count = r_out.entry_count;

endmodule

@@ sv/ole_chk.sv @@
module ole_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [ole_pkg::VAL_W-1:0]  o_read_value,
    input logic                              o_found,
    input logic [ole_pkg::STATUS_W-1:0]      o_status
);

    // A result beat stays offered while it is stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat withdrawn while stalled");

    // Requests are worked on one at a time: a taken request closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while another is in progress");

    // Only a successful request can report a match.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ole_pkg::ST_OK)
        else $error("found flag on a refused request");

    // A refused request reads nothing.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ole_pkg::ST_OK) |-> o_read_value == '0)
        else $error("read value on a refused request");

endmodule

bind ordered_list_engine ole_chk u_ole_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value),
    .o_found      (o_found),
    .o_status     (o_status)
);
